@@ hw/rtl/tnp_pkg.sv @@
// Types, byte codes and reply policy shared by the telnet option parser.
package tnp_pkg;

    typedef enum logic [2:0] {
        ST_NORMAL = 3'd0,
        ST_IAC    = 3'd1,
        ST_OPT    = 3'd2,
        ST_SB     = 3'd3,
        ST_DATA   = 3'd4,
        ST_SE     = 3'd5,
        ST_EOL    = 3'd6
    } parser_state_t;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_WINSIZE = 2'd2
    } kind_t;

    localparam logic       OP_BYTE  = 1'b0;
    localparam logic       OP_START = 1'b1;

    localparam logic [1:0] CFG_DEFAULT_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_ROWS    = 2'd1;

    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_CR   = 8'd13;
    localparam logic [7:0] B_LF   = 8'd10;

    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;
    localparam logic [7:0] OPT_TTYPE  = 8'd24;
    localparam logic [7:0] OPT_NAWS   = 8'd31;
    localparam logic [7:0] OPT_TSPEED = 8'd32;

    localparam int NAWS_LEN = 4;

    localparam logic [15:0] RESET_COLUMNS = 16'd80;
    localparam logic [15:0] RESET_ROWS    = 16'd25;

    function automatic logic [7:0] reply_code(logic [7:0] code, logic [7:0] option);
        logic from_will;
        from_will = (code == B_WILL) || (code == B_WONT);
        if (option == OPT_SGA)
            reply_code = from_will ? B_DO : B_WILL;
        else if (option == OPT_TTYPE || option == OPT_NAWS || option == OPT_TSPEED)
            reply_code = B_DO;
        else
            reply_code = from_will ? B_DONT : B_WONT;
    endfunction

endpackage

@@ hw/rtl/tnp_rx_if.sv @@
// Request channel carrying received telnet bytes and session starts.
interface tnp_rx_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

@@ hw/rtl/tnp_tx_if.sv @@
// Result channel carrying shell data, peer replies and window size reports.
interface tnp_tx_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        last;
    logic [15:0] columns;
    logic [15:0] rows;

    modport source (output valid, output kind, output out_byte, output last,
                    output columns, output rows, input ready);
    modport sink   (input valid, input kind, input out_byte, input last,
                    input columns, input rows, output ready);
endinterface

@@ hw/rtl/tnp_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface tnp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/telnet_option_parser.sv @@
// Telnet receive-side option parser top level.
//
//  channel  role    payload
//  rx       sink    op, rx_byte
//  tx       source  kind, out_byte, last, columns, rows
//  cfg      sink    index, data (default_columns, default_rows)
//
// One request a cycle enters the input register while it has room; it is parsed
// combinationally and, once the result buffer is free, loaded into it as up to
// three results, which drain one per cycle on tx while tx is ready. They occupy
// the buffer until the last is taken; the input register holds one more request.
// Reset clears the parser to normal, sizes to 80 x 25, buffers empty.
// A stalled tx holds the buffer; rx stalls only once the input register is full.
module telnet_option_parser #(
    parameter int SUB_BUFFER_LEN = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    tnp_rx_if.sink   rx,
    tnp_tx_if.source tx,
    tnp_cfg_if.sink  cfg
);

    localparam int CNT_W = $clog2(SUB_BUFFER_LEN + 1);

    tnp_pkg::parser_state_t state_reg, state_next;
    logic [7:0]       pend_reg, pend_next;
    logic [CNT_W-1:0] sub_count_reg, sub_count_next;
    logic [7:0]       sub_data_reg [4];
    logic             sub_we;
    logic [15:0]      cols_reg, cols_next;
    logic [15:0]      rows_reg, rows_next;
    logic [15:0]      def_cols_reg;
    logic [15:0]      def_rows_reg;

    logic             inp_valid_reg;
    logic             inp_op_reg;
    logic [7:0]       inp_byte_reg;

    logic [1:0]       res_cnt_reg;
    tnp_pkg::kind_t   slot_kind_reg [3];
    logic [7:0]       slot_byte_reg [3];

    logic [1:0]       n_res;
    tnp_pkg::kind_t   new_kind [3];
    logic [7:0]       new_byte [3];

    logic             buf_free;
    logic             consume;
    logic             tx_take;
    logic [15:0]      naws_cols;
    logic [15:0]      naws_rows;

    assign tx_take  = tx.valid && tx.ready;
    assign buf_free = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && tx.ready);
    assign consume  = inp_valid_reg && buf_free;
    assign rx.ready = !inp_valid_reg || consume;
    assign cfg.ready = 1'b1;

    assign naws_cols = {sub_data_reg[0], sub_data_reg[1]};
    assign naws_rows = {sub_data_reg[2], sub_data_reg[3]};

    // next parser state
    always_comb
    begin
        state_next = state_reg;
        if (inp_op_reg == tnp_pkg::OP_START)
        begin
            state_next = tnp_pkg::ST_NORMAL;
        end
        else
        begin
            unique case (state_reg)
                tnp_pkg::ST_IAC:
                begin
                    if (inp_byte_reg == tnp_pkg::B_IAC)
                        state_next = tnp_pkg::ST_NORMAL;
                    else if (inp_byte_reg >= tnp_pkg::B_WILL
                             && inp_byte_reg <= tnp_pkg::B_DONT)
                        state_next = tnp_pkg::ST_OPT;
                    else if (inp_byte_reg == tnp_pkg::B_SB)
                        state_next = tnp_pkg::ST_SB;
                    else
                        state_next = tnp_pkg::ST_NORMAL;
                end
                tnp_pkg::ST_OPT:  state_next = tnp_pkg::ST_NORMAL;
                tnp_pkg::ST_SB:   state_next = tnp_pkg::ST_DATA;
                tnp_pkg::ST_DATA:
                begin
                    if (inp_byte_reg == tnp_pkg::B_IAC)
                        state_next = tnp_pkg::ST_SE;
                end
                tnp_pkg::ST_SE:   state_next = tnp_pkg::ST_NORMAL;
                tnp_pkg::ST_EOL:
                begin
                    if (inp_byte_reg == tnp_pkg::B_IAC)
                        state_next = tnp_pkg::ST_IAC;
                    else
                        state_next = tnp_pkg::ST_NORMAL;
                end
                default:
                begin
                    if (inp_byte_reg == tnp_pkg::B_IAC)
                        state_next = tnp_pkg::ST_IAC;
                    else if (inp_byte_reg == tnp_pkg::B_CR)
                        state_next = tnp_pkg::ST_EOL;
                    else
                        state_next = tnp_pkg::ST_NORMAL;
                end
            endcase
        end
    end

    // results and data-path updates
    always_comb
    begin
        pend_next      = pend_reg;
        sub_count_next = sub_count_reg;
        sub_we         = 1'b0;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        n_res          = 2'd0;
        new_kind[0]    = tnp_pkg::KIND_DATA;
        new_kind[1]    = tnp_pkg::KIND_REPLY;
        new_kind[2]    = tnp_pkg::KIND_REPLY;
        new_byte[0]    = inp_byte_reg;
        new_byte[1]    = 8'd0;
        new_byte[2]    = 8'd0;
        if (inp_op_reg == tnp_pkg::OP_START)
        begin
            pend_next      = 8'd0;
            sub_count_next = '0;
            cols_next      = (def_cols_reg != 16'd0) ? def_cols_reg : 16'd1;
            rows_next      = (def_rows_reg != 16'd0) ? def_rows_reg : 16'd1;
            n_res          = 2'd3;
            new_kind[0]    = tnp_pkg::KIND_REPLY;
            new_byte[0]    = tnp_pkg::B_IAC;
            new_byte[1]    = tnp_pkg::B_WILL;
            new_byte[2]    = tnp_pkg::OPT_ECHO;
        end
        else
        begin
            unique case (state_reg)
                tnp_pkg::ST_IAC:
                begin
                    if (inp_byte_reg == tnp_pkg::B_IAC)
                        n_res = 2'd1;
                    else if (inp_byte_reg >= tnp_pkg::B_WILL
                             && inp_byte_reg <= tnp_pkg::B_DONT)
                        pend_next = inp_byte_reg;
                end
                tnp_pkg::ST_OPT:
                begin
                    if (inp_byte_reg != tnp_pkg::OPT_ECHO)
                    begin
                        n_res       = 2'd3;
                        new_kind[0] = tnp_pkg::KIND_REPLY;
                        new_byte[0] = tnp_pkg::B_IAC;
                        new_byte[1] = tnp_pkg::reply_code(pend_reg, inp_byte_reg);
                        new_byte[2] = inp_byte_reg;
                    end
                end
                tnp_pkg::ST_SB:
                begin
                    pend_next      = inp_byte_reg;
                    sub_count_next = '0;
                end
                tnp_pkg::ST_DATA:
                begin
                    if (inp_byte_reg != tnp_pkg::B_IAC
                        && sub_count_reg < CNT_W'(SUB_BUFFER_LEN))
                    begin
                        sub_we         = (sub_count_reg < CNT_W'(tnp_pkg::NAWS_LEN));
                        sub_count_next = sub_count_reg + 1'b1;
                    end
                end
                tnp_pkg::ST_SE:
                begin
                    if (inp_byte_reg == tnp_pkg::B_SE && pend_reg == tnp_pkg::OPT_NAWS
                        && sub_count_reg == CNT_W'(tnp_pkg::NAWS_LEN))
                    begin
                        if (naws_cols != 16'd0)
                            cols_next = naws_cols;
                        if (naws_rows != 16'd0)
                            rows_next = naws_rows;
                        n_res       = 2'd1;
                        new_kind[0] = tnp_pkg::KIND_WINSIZE;
                        new_byte[0] = 8'd0;
                    end
                end
                tnp_pkg::ST_EOL:
                begin
                    if (inp_byte_reg != tnp_pkg::B_IAC && inp_byte_reg != tnp_pkg::B_LF)
                        n_res = 2'd1;
                end
                default:
                begin
                    if (inp_byte_reg != tnp_pkg::B_IAC)
                        n_res = 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inp_valid_reg <= 1'b0;
            res_cnt_reg   <= 2'd0;
            state_reg     <= tnp_pkg::ST_NORMAL;
            pend_reg      <= 8'd0;
            sub_count_reg <= '0;
            cols_reg      <= tnp_pkg::RESET_COLUMNS;
            rows_reg      <= tnp_pkg::RESET_ROWS;
            def_cols_reg  <= tnp_pkg::RESET_COLUMNS;
            def_rows_reg  <= tnp_pkg::RESET_ROWS;
        end
        else
        begin
            if (rx.valid && rx.ready)
                inp_valid_reg <= 1'b1;
            else if (consume)
                inp_valid_reg <= 1'b0;

            if (consume)
            begin
                res_cnt_reg   <= n_res;
                state_reg     <= state_next;
                pend_reg      <= pend_next;
                sub_count_reg <= sub_count_next;
                cols_reg      <= cols_next;
                rows_reg      <= rows_next;
            end
            else if (tx_take)
            begin
                res_cnt_reg <= res_cnt_reg - 2'd1;
            end

            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == tnp_pkg::CFG_DEFAULT_COLUMNS)
                    def_cols_reg <= cfg.data;
                else if (cfg.index == tnp_pkg::CFG_DEFAULT_ROWS)
                    def_rows_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            inp_op_reg   <= rx.op;
            inp_byte_reg <= rx.rx_byte;
        end

        if (consume && sub_we)
            sub_data_reg[sub_count_reg[1:0]] <= inp_byte_reg;

        if (consume)
        begin
            for (int i = 0; i < 3; i++)
            begin
                slot_kind_reg[i] <= new_kind[i];
                slot_byte_reg[i] <= new_byte[i];
            end
        end
        else if (tx_take)
        begin
            slot_kind_reg[0] <= slot_kind_reg[1];
            slot_byte_reg[0] <= slot_byte_reg[1];
            slot_kind_reg[1] <= slot_kind_reg[2];
            slot_byte_reg[1] <= slot_byte_reg[2];
        end
    end

    assign tx.valid    = (res_cnt_reg != 2'd0);
    assign tx.kind     = slot_kind_reg[0];
    assign tx.out_byte = slot_byte_reg[0];
    assign tx.last     = (res_cnt_reg == 2'd1);
    assign tx.columns  = cols_reg;
    assign tx.rows     = rows_reg;

`ifndef SYNTHESIS
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && inp_op_reg == tnp_pkg::OP_START) |=>
            (state_reg == tnp_pkg::ST_NORMAL && sub_count_reg == '0 && res_cnt_reg == 2'd3
             && slot_byte_reg[0] == tnp_pkg::B_IAC))
        else $error("session start did not clear parser or load reply");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cols_reg != 16'd0) && (rows_reg != 16'd0))
        else $error("terminal size became zero");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sub_count_reg <= CNT_W'(SUB_BUFFER_LEN))
        else $error("subnegotiation count beyond buffer length");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && n_res != 2'd0) |=> tx.valid)
        else $error("parsed results lost");
`endif

endmodule
